// ----- sv/bsc_pkg.sv -----
// Shared types and constants for the barometric sensor compensation block.
// No dependencies; every other file refers to it by scoped names.
package bsc_pkg;

   // Field widths
   localparam int RAW_W   = 20;
   localparam int TEMP_W  = 16;
   localparam int PRESS_W = 25;
   localparam int CSR_DW  = 64;
   localparam int CSR_AW  = 2;

   // Compensation constants
   localparam logic signed [24:0] T_FINE_OFFSET = 25'sd128000;
   localparam logic [20:0]        P_FULL_SCALE  = 21'd1048576;
   localparam logic signed [63:0] P_SCALE       = 64'sd3125;
   localparam logic signed [63:0] DIV_BIAS      = 64'sh0000_8000_0000_0000;
   localparam logic signed [63:0] PRESS_MAX     = 64'sd33554431;
   localparam int DIV_STEPS = 64;

   // Configuration register indexes
   localparam logic [CSR_AW-1:0] CSR_TEMP_CAL = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_PRESS_A  = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_PRESS_B  = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_PRESS_C  = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_READ_FAILED = 2'd1,
      STATUS_DIV_ZERO    = 2'd2
   } status_type;

   // Unpacked calibration words
   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } cal_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw_pressure;
      logic [RAW_W-1:0] raw_temperature;
      logic             read_failed;
   } req_beat_type;

   // Front end to divider
   typedef struct packed {
      logic                valid;
      status_type          status;
      logic [TEMP_W-1:0]   tcent;
      logic signed [63:0]  num;
      logic signed [30:0]  divisor;
   } front_out_type;

   // Divider to back end
   typedef struct packed {
      logic               valid;
      status_type         status;
      logic [TEMP_W-1:0]  tcent;
      logic               neg;
      logic [63:0]        quot;
   } div_out_type;

   typedef struct packed {
      logic [TEMP_W-1:0]  temperature_centi;
      logic [PRESS_W-1:0] pressure_q24_8;
      status_type         status;
   } rsp_beat_type;

   typedef struct packed {
      logic         valid;
      rsp_beat_type beat;
   } back_out_type;

endpackage

// ----- sv/bsc_if.sv -----
// Channel interfaces for the request and response sides.
// Depends on bsc_pkg for field widths.
interface bsc_req_if;
   logic                      valid;
   logic                      ready;
   logic [bsc_pkg::RAW_W-1:0] raw_pressure;
   logic [bsc_pkg::RAW_W-1:0] raw_temperature;
   logic                      read_failed;

   modport source (output valid, raw_pressure, raw_temperature, read_failed, input ready);
   modport sink (input valid, raw_pressure, raw_temperature, read_failed, output ready);
endinterface

interface bsc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bsc_pkg::TEMP_W-1:0]  temperature_centi;
   logic [bsc_pkg::PRESS_W-1:0] pressure_q24_8;
   logic [1:0]                  status;

   modport source (output valid, temperature_centi, pressure_q24_8, status, input ready);
   modport sink (input valid, temperature_centi, pressure_q24_8, status, output ready);
endinterface

// ----- sv/bsc_front.sv -----
// Front end: temperature compensation and the pressure numerator/divisor.
// Nine register stages; depends on bsc_pkg.
module bsc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  bsc_pkg::req_beat_type in_beat,
   input  bsc_pkg::cal_type      cal,
   output bsc_pkg::front_out_type out
);

   // Stage 1: input beat
   logic v1_ff, rf1_ff;
   logic [19:0] adp1_ff, adt1_ff;
   // Stage 2: first temperature products
   logic v2_ff, rf2_ff;
   logic [19:0] adp2_ff;
   logic signed [33:0] ta2_ff, dd2_ff, ta2_in, dd2_in;
   // Stage 3
   logic v3_ff, rf3_ff;
   logic [19:0] adp3_ff;
   logic signed [22:0] a3_ff, a3_in;
   logic signed [37:0] b3_ff, b3_in;
   // Stage 4
   logic v4_ff, rf4_ff;
   logic [19:0] adp4_ff;
   logic [15:0] tc4_ff, tc4_in;
   logic signed [24:0] pa4_ff, pa4_in;
   // Stage 5
   logic v5_ff, rf5_ff;
   logic [19:0] adp5_ff;
   logic [15:0] tc5_ff;
   logic signed [49:0] aa5_ff, aa5_in;
   logic signed [40:0] ap5_5_ff, ap5_5_in, ap2_5_ff, ap2_5_in;
   // Stage 6
   logic v6_ff, rf6_ff;
   logic [19:0] adp6_ff;
   logic [15:0] tc6_ff;
   logic signed [63:0] m6_6_ff, m6_6_in, m3_6_ff, m3_6_in;
   logic signed [40:0] ap5_6_ff, ap2_6_ff;
   // Stage 7
   logic v7_ff, rf7_ff;
   logic [19:0] adp7_ff;
   logic [15:0] tc7_ff;
   logic signed [63:0] acc7_ff, acc7_in, dsum7_ff, dsum7_in;
   // Stage 8
   logic v8_ff, rf8_ff;
   logic [15:0] tc8_ff;
   logic signed [63:0] dprod8_ff, dprod8_in, np8_ff, np8_in;
   // Stage 9
   logic v9_ff;
   bsc_pkg::status_type st9_ff, st9_in;
   logic [15:0] tc9_ff;
   logic signed [63:0] num9_ff, num9_in;
   logic signed [30:0] dv9_ff, dv9_in;

   logic signed [17:0] tdx;
   logic signed [16:0] tdd;
   logic signed [24:0] tf;
   logic signed [27:0] t5;
   logic signed [19:0] tsh;
   logic [20:0] pr;

   // Temperature products
   always_comb begin
      tdx    = $signed({1'b0, adt1_ff[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
      tdd    = $signed({1'b0, adt1_ff[19:4]}) - $signed({1'b0, cal.t1});
      ta2_in = 34'(tdx * cal.t2);
      dd2_in = 34'(tdd * tdd);
   end

   // Scale the two temperature terms
   always_comb begin
      a3_in = 23'(ta2_ff >>> 11);
      b3_in = 38'((dd2_ff >>> 12) * cal.t3);
   end

   // Fine temperature, centidegrees with saturation, pressure offset
   always_comb begin
      tf  = 25'(a3_ff + (b3_ff >>> 14));
      t5  = 28'(tf * 28'sd5 + 28'sd128);
      tsh = 20'(t5 >>> 8);
      if (tsh > 20'sd32767) begin
         tc4_in = 16'h7FFF;
      end else if (tsh < -20'sd32768) begin
         tc4_in = 16'h8000;
      end else begin
         tc4_in = tsh[15:0];
      end
      pa4_in = tf - bsc_pkg::T_FINE_OFFSET;
   end

   // First pressure products
   always_comb begin
      aa5_in   = 50'(pa4_ff * pa4_ff);
      ap5_5_in = 41'(pa4_ff * cal.p5);
      ap2_5_in = 41'(pa4_ff * cal.p2);
   end

   // Quadratic terms, wrapped to 64 bits
   always_comb begin
      m6_6_in = 64'(aa5_ff * cal.p6);
      m3_6_in = 64'(aa5_ff * cal.p3);
   end

   // Sum the numerator offset and the divisor polynomial
   always_comb begin
      acc7_in  = m6_6_ff + (64'(ap5_6_ff) << 17) + (64'(cal.p4) << 35);
      dsum7_in = (m3_6_ff >>> 8) + (64'(ap2_6_ff) << 12) + bsc_pkg::DIV_BIAS;
   end

   // Divisor product and raw numerator
   always_comb begin
      pr        = bsc_pkg::P_FULL_SCALE - {1'b0, adp7_ff};
      dprod8_in = 64'(dsum7_ff * $signed({1'b0, cal.p1}));
      np8_in    = $signed({12'd0, pr, 31'd0}) - acc7_ff;
   end

   // Final divisor, scaled numerator and status
   always_comb begin
      dv9_in  = dprod8_ff[63:33];
      num9_in = 64'(np8_ff * bsc_pkg::P_SCALE);
      if (rf8_ff) begin
         st9_in = bsc_pkg::STATUS_READ_FAILED;
      end else if (dv9_in == 31'sd0) begin
         st9_in = bsc_pkg::STATUS_DIV_ZERO;
      end else begin
         st9_in = bsc_pkg::STATUS_OK;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
         v7_ff <= 1'b0; v8_ff <= 1'b0; v9_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff;
         v4_ff <= v3_ff; v5_ff <= v4_ff; v6_ff <= v5_ff;
         v7_ff <= v6_ff; v8_ff <= v7_ff; v9_ff <= v8_ff;
      end
   end

   // Payload, advanced with the valid bits
   always_ff @(posedge clock) begin
      if (en) begin
         rf1_ff <= in_beat.read_failed;
         adp1_ff <= in_beat.raw_pressure;
         adt1_ff <= in_beat.raw_temperature;
         rf2_ff <= rf1_ff; adp2_ff <= adp1_ff; ta2_ff <= ta2_in; dd2_ff <= dd2_in;
         rf3_ff <= rf2_ff; adp3_ff <= adp2_ff; a3_ff <= a3_in; b3_ff <= b3_in;
         rf4_ff <= rf3_ff; adp4_ff <= adp3_ff; tc4_ff <= tc4_in; pa4_ff <= pa4_in;
         rf5_ff <= rf4_ff; adp5_ff <= adp4_ff; tc5_ff <= tc4_ff;
         aa5_ff <= aa5_in; ap5_5_ff <= ap5_5_in; ap2_5_ff <= ap2_5_in;
         rf6_ff <= rf5_ff; adp6_ff <= adp5_ff; tc6_ff <= tc5_ff;
         m6_6_ff <= m6_6_in; m3_6_ff <= m3_6_in; ap5_6_ff <= ap5_5_ff; ap2_6_ff <= ap2_5_ff;
         rf7_ff <= rf6_ff; adp7_ff <= adp6_ff; tc7_ff <= tc6_ff;
         acc7_ff <= acc7_in; dsum7_ff <= dsum7_in;
         rf8_ff <= rf7_ff; tc8_ff <= tc7_ff; dprod8_ff <= dprod8_in; np8_ff <= np8_in;
         st9_ff <= st9_in; tc9_ff <= tc8_ff; num9_ff <= num9_in; dv9_ff <= dv9_in;
      end
   end

   assign out.valid   = v9_ff;
   assign out.status  = st9_ff;
   assign out.tcent   = tc9_ff;
   assign out.num     = num9_ff;
   assign out.divisor = dv9_ff;

endmodule

// ----- sv/bsc_div.sv -----
// Pipelined signed divider: one restoring step per stage, 64 stages plus setup.
// Depends on bsc_pkg.
module bsc_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  bsc_pkg::front_out_type in,
   output bsc_pkg::div_out_type   out
);

   typedef struct packed {
      logic                valid;
      bsc_pkg::status_type status;
      logic [15:0]         tcent;
      logic                neg;
      logic [30:0]         rem;
      logic [63:0]         dq;
      logic [30:0]         ub;
   } stage_type;

   stage_type stage_ff [0:bsc_pkg::DIV_STEPS];
   stage_type setup_in;
   logic [30:0] div_mag;

   // One quotient bit: shift in the next dividend bit, subtract if it fits
   function automatic stage_type div_step(stage_type s);
      stage_type   r;
      logic [31:0] trial;
      logic [31:0] diff;
      r     = s;
      trial = {s.rem, s.dq[63]};
      diff  = trial - {1'b0, s.ub};
      r.rem = diff[31] ? trial[30:0] : diff[30:0];
      r.dq  = {s.dq[62:0], ~diff[31]};
      return r;
   endfunction

   // Take magnitudes and the quotient sign
   always_comb begin
      div_mag        = in.divisor[30] ? 31'(-in.divisor) : in.divisor;
      setup_in.valid  = in.valid;
      setup_in.status = in.status;
      setup_in.tcent  = in.tcent;
      setup_in.neg    = in.num[63] ^ in.divisor[30];
      setup_in.rem    = '0;
      setup_in.dq     = in.num[63] ? 64'(-in.num) : in.num;
      setup_in.ub     = div_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff[0].valid <= 1'b0;
      end else if (en) begin
         stage_ff[0] <= setup_in;
      end
   end

   // Divider stages
   for (genvar i = 0; i < bsc_pkg::DIV_STEPS; i++) begin : g_step
      stage_type step_in;
      assign step_in = div_step(stage_ff[i]);
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[i+1].valid <= 1'b0;
         end else if (en) begin
            stage_ff[i+1] <= step_in;
         end
      end
   end

   assign out.valid  = stage_ff[bsc_pkg::DIV_STEPS].valid;
   assign out.status = stage_ff[bsc_pkg::DIV_STEPS].status;
   assign out.tcent  = stage_ff[bsc_pkg::DIV_STEPS].tcent;
   assign out.neg    = stage_ff[bsc_pkg::DIV_STEPS].neg;
   assign out.quot   = stage_ff[bsc_pkg::DIV_STEPS].dq;

endmodule

// ----- sv/bsc_back.sv -----
// Back end: quadratic pressure correction, offset and output saturation.
// Five register stages; depends on bsc_pkg.
module bsc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  bsc_pkg::div_out_type  in,
   input  bsc_pkg::cal_type      cal,
   output bsc_pkg::back_out_type out
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   bsc_pkg::status_type st1_ff, st2_ff, st3_ff, st4_ff;
   logic [15:0] tc1_ff, tc2_ff, tc3_ff, tc4_ff;
   logic signed [63:0] p1_ff, p1_in, p2_ff, p3_ff, p4_ff;
   logic [63:0] s13;
   logic [63:0] ll2_ff, ll2_in;
   logic [30:0] cr2_ff, cr2_in;
   logic signed [63:0] q2r2_ff, q2r2_in, q2r3_ff;
   logic [63:0] sq3_ff, sq3_in;
   logic signed [63:0] q1m, q1_4_ff, q1_4_in, q2_4_ff, q2_4_in;
   logic signed [63:0] pp;
   bsc_pkg::rsp_beat_type res5_ff, res5_in;

   // Apply the quotient sign
   assign p1_in = in.neg ? 64'(-$signed(in.quot)) : $signed(in.quot);

   // Partial products of the squared term, linear term
   always_comb begin
      s13     = 64'(p1_ff >>> 13);
      ll2_in  = 64'(s13[31:0] * s13[31:0]);
      cr2_in  = 31'(s13[31:0] * s13[63:32]);
      q2r2_in = 64'(p1_ff * cal.p8);
   end

   // Combine into the low 64 bits of the square
   assign sq3_in = ll2_ff + {cr2_ff, 33'd0};

   // Scale both correction terms
   always_comb begin
      q1m     = 64'($signed(sq3_ff) * cal.p9);
      q1_4_in = q1m >>> 25;
      q2_4_in = q2r3_ff >>> 19;
   end

   // Sum, offset, saturate; force zeros on error
   always_comb begin
      pp = ((p4_ff + q1_4_ff + q2_4_ff) >>> 8) + (64'(cal.p7) << 4);
      res5_in.status            = st4_ff;
      res5_in.temperature_centi = tc4_ff;
      if (pp < 64'sd0) begin
         res5_in.pressure_q24_8 = '0;
      end else if (pp > bsc_pkg::PRESS_MAX) begin
         res5_in.pressure_q24_8 = '1;
      end else begin
         res5_in.pressure_q24_8 = pp[24:0];
      end
      if (st4_ff != bsc_pkg::STATUS_OK) begin
         res5_in.temperature_centi = '0;
         res5_in.pressure_q24_8    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in.valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff; v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st1_ff <= in.status; tc1_ff <= in.tcent; p1_ff <= p1_in;
         st2_ff <= st1_ff; tc2_ff <= tc1_ff; p2_ff <= p1_ff;
         ll2_ff <= ll2_in; cr2_ff <= cr2_in; q2r2_ff <= q2r2_in;
         st3_ff <= st2_ff; tc3_ff <= tc2_ff; p3_ff <= p2_ff;
         sq3_ff <= sq3_in; q2r3_ff <= q2r2_ff;
         st4_ff <= st3_ff; tc4_ff <= tc3_ff; p4_ff <= p3_ff;
         q1_4_ff <= q1_4_in; q2_4_ff <= q2_4_in;
         res5_ff <= res5_in;
      end
   end

   assign out.valid = v5_ff;
   assign out.beat  = res5_ff;

endmodule

// ----- sv/barometric_sensor_compensation.sv -----
// Top level: calibration registers, compensation pipeline, output skid buffer.
// Depends on bsc_pkg, bsc_if, bsc_front, bsc_div and bsc_back.
//
//   channel   direction  handshake      payload
//   req       in         valid/ready    raw_pressure, raw_temperature, read_failed
//   rsp       out        valid/ready    temperature_centi, pressure_q24_8, status
//   csr       in         write enable   csr_index, csr_write_data
//
// One beat enters per cycle while the skid buffer is not full; the path runs through 9 front stages, setup plus
// 64 divider steps, 5 back stages and 1 skid slot. The 64-step divider sets the depth.
// Reset is synchronous and clears valid bits, skid count and calibration words.
// The whole pipeline holds while the 2-entry skid buffer is full; a beat waiting
// at the output does not block new requests until the buffer fills.
module barometric_sensor_compensation (
   input  logic                         clock,
   input  logic                         reset,
   bsc_req_if.sink                      req,
   bsc_rsp_if.source                    rsp,
   input  logic                         csr_write_enable,
   input  logic [bsc_pkg::CSR_AW-1:0]   csr_index,
   input  logic [bsc_pkg::CSR_DW-1:0]   csr_write_data
);

   logic [47:0] temp_cal_ff;
   logic [63:0] press_a_ff, press_b_ff;
   logic [15:0] press_c_ff;
   bsc_pkg::cal_type       cal;
   bsc_pkg::req_beat_type  in_beat;
   bsc_pkg::front_out_type front_out;
   bsc_pkg::div_out_type   div_out;
   bsc_pkg::back_out_type  back_out;
   logic en, push, pop;
   logic [1:0] cnt_ff, cnt_in;
   bsc_pkg::rsp_beat_type slot0_ff, slot0_in, slot1_ff, slot1_in;

   // Calibration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff <= '0;
         press_a_ff  <= '0;
         press_b_ff  <= '0;
         press_c_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            bsc_pkg::CSR_TEMP_CAL: temp_cal_ff <= csr_write_data[47:0];
            bsc_pkg::CSR_PRESS_A:  press_a_ff  <= csr_write_data;
            bsc_pkg::CSR_PRESS_B:  press_b_ff  <= csr_write_data;
            bsc_pkg::CSR_PRESS_C:  press_c_ff  <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // Unpack calibration words
   always_comb begin
      cal.t1 = temp_cal_ff[15:0];
      cal.t2 = $signed(temp_cal_ff[31:16]);
      cal.t3 = $signed(temp_cal_ff[47:32]);
      cal.p1 = press_a_ff[15:0];
      cal.p2 = $signed(press_a_ff[31:16]);
      cal.p3 = $signed(press_a_ff[47:32]);
      cal.p4 = $signed(press_a_ff[63:48]);
      cal.p5 = $signed(press_b_ff[15:0]);
      cal.p6 = $signed(press_b_ff[31:16]);
      cal.p7 = $signed(press_b_ff[47:32]);
      cal.p8 = $signed(press_b_ff[63:48]);
      cal.p9 = $signed(press_c_ff);
   end

   // Advance the pipeline unless the skid buffer is full
   assign en        = (cnt_ff != 2'd2);
   assign req.ready = en;

   assign in_beat.raw_pressure    = req.raw_pressure;
   assign in_beat.raw_temperature = req.raw_temperature;
   assign in_beat.read_failed     = req.read_failed;

   bsc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req.valid),
      .in_beat  (in_beat),
      .cal      (cal),
      .out      (front_out)
   );

   bsc_div u_div (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in    (front_out),
      .out   (div_out)
   );

   bsc_back u_back (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in    (div_out),
      .cal   (cal),
      .out   (back_out)
   );

   // Skid buffer: slot0 is the head
   assign push = en && back_out.valid;
   assign pop  = rsp.valid && rsp.ready;

   always_comb begin
      cnt_in   = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         if (cnt_ff == 2'd2) begin
            slot0_in = slot1_ff;
         end else begin
            slot0_in = back_out.beat;
         end
      end else if (cnt_ff == 2'd0) begin
         slot0_in = back_out.beat;
      end
      if (push && !pop && cnt_ff == 2'd1) begin
         slot1_in = back_out.beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp.valid             = (cnt_ff != 2'd0);
   assign rsp.temperature_centi = slot0_ff.temperature_centi;
   assign rsp.pressure_q24_8    = slot0_ff.pressure_q24_8;
   assign rsp.status            = slot0_ff.status;

   // Error results carry zero fields
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != bsc_pkg::STATUS_OK) |->
      (rsp.temperature_centi == '0 && rsp.pressure_q24_8 == '0))
      else $error("error result with nonzero fields");

   // Skid count stays within two entries
   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("skid count overflow");

   // Draining the last entry without a refill empties the output
   a_drain : assert property (@(posedge clock) disable iff (reset)
      (pop && !push && cnt_ff == 2'd1) |=> !rsp.valid)
      else $error("output valid after draining last entry");

endmodule

// ----- bench/barometric_sensor_compensation_tb.sv -----
// Self-checking bench for the barometric sensor compensation block.
// Depends on bsc_pkg, bsc_if and the block's RTL; predicts every response in-bench.
module barometric_sensor_compensation_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [bsc_pkg::CSR_AW-1:0] csr_index;
   logic [bsc_pkg::CSR_DW-1:0] csr_write_data;

   bsc_req_if req ();
   bsc_rsp_if rsp ();

   barometric_sensor_compensation i_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Bench copy of the calibration registers
   logic [47:0] cal_temp;
   logic [63:0] cal_press_a;
   logic [63:0] cal_press_b;
   logic [15:0] cal_press_c;

   bsc_pkg::rsp_beat_type pending_readings[$];
   int mismatch_count = 0;
   bit quiet = 0;
   int stall_left = 0;

   // Clock: 2 ns period
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic [63:0] sext16(input logic [15:0] w);
      return {{48{w[15]}}, w};
   endfunction

   function automatic logic [63:0] shift_arith(input logic [63:0] x, input int n);
      return $signed(x) >>> n;
   endfunction

   // Predict one response; the pressure path wraps modulo 2^64
   function automatic bsc_pkg::rsp_beat_type compensate(input logic [19:0] raw_p,
                                                        input logic [19:0] raw_t,
                                                        input logic failed);
      logic [63:0] adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] a, b, d, tf, acc, dv, p, q1, q2, num, ua, ub, uq;
      logic signed [63:0] tc, ps;
      bsc_pkg::rsp_beat_type r;
      adc_p = {44'd0, raw_p};
      adc_t = {44'd0, raw_t};
      t1 = {48'd0, cal_temp[15:0]};
      t2 = sext16(cal_temp[31:16]);
      t3 = sext16(cal_temp[47:32]);
      p1 = {48'd0, cal_press_a[15:0]};
      p2 = sext16(cal_press_a[31:16]);
      p3 = sext16(cal_press_a[47:32]);
      p4 = sext16(cal_press_a[63:48]);
      p5 = sext16(cal_press_b[15:0]);
      p6 = sext16(cal_press_b[31:16]);
      p7 = sext16(cal_press_b[47:32]);
      p8 = sext16(cal_press_b[63:48]);
      p9 = sext16(cal_press_c);
      r.temperature_centi = '0;
      r.pressure_q24_8 = '0;
      if (failed) begin
         r.status = bsc_pkg::STATUS_READ_FAILED;
         return r;
      end
      // Temperature path and fine temperature
      a = shift_arith(((adc_t >> 3) - (t1 << 1)) * t2, 11);
      d = (adc_t >> 4) - t1;
      b = shift_arith(shift_arith(d * d, 12) * t3, 14);
      tf = a + b;
      tc = $signed(shift_arith(tf * 64'd5 + 64'd128, 8));
      if (tc > 64'sd32767) tc = 64'sd32767;
      if (tc < -64'sd32768) tc = -64'sd32768;
      // Pressure numerator offset and divisor
      a = tf - 64'd128000;
      acc = a * a * p6;
      acc = acc + ((a * p5) << 17);
      acc = acc + (p4 << 35);
      dv = shift_arith(a * a * p3, 8) + ((a * p2) << 12);
      dv = (64'h0000_8000_0000_0000 + dv) * p1;
      dv = shift_arith(dv, 33);
      if (dv == 64'd0) begin
         r.status = bsc_pkg::STATUS_DIV_ZERO;
         return r;
      end
      p = 64'd1048576 - adc_p;
      num = ((p << 31) - acc) * 64'd3125;
      // Divide on magnitudes, truncating toward zero
      ua = num[63] ? 64'd0 - num : num;
      ub = dv[63] ? 64'd0 - dv : dv;
      uq = ua / ub;
      p = (num[63] ^ dv[63]) ? 64'd0 - uq : uq;
      q1 = shift_arith(p9 * shift_arith(p, 13) * shift_arith(p, 13), 25);
      q2 = shift_arith(p8 * p, 19);
      p = shift_arith(p + q1 + q2, 8) + (p7 << 4);
      ps = $signed(p);
      if (ps < 0) ps = 0;
      if (ps > bsc_pkg::PRESS_MAX) ps = bsc_pkg::PRESS_MAX;
      r.temperature_centi = tc[15:0];
      r.pressure_q24_8 = ps[24:0];
      r.status = bsc_pkg::STATUS_OK;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Response stall bursts
   always @(negedge clock) begin
      if (quiet) begin
         rsp.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // Compare each response beat with the oldest prediction
   always @(posedge clock) begin
      bsc_pkg::rsp_beat_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("unexpected beat", {39'd0, rsp.pressure_q24_8}, 64'd0);
         end else begin
            want = pending_readings.pop_front();
            if (rsp.temperature_centi !== want.temperature_centi)
               report_mismatch("temperature_centi", 64'(rsp.temperature_centi),
                               64'(want.temperature_centi));
            if (rsp.pressure_q24_8 !== want.pressure_q24_8)
               report_mismatch("pressure_q24_8", 64'(rsp.pressure_q24_8),
                               64'(want.pressure_q24_8));
            if (rsp.status !== want.status)
               report_mismatch("status", 64'(rsp.status), 64'(want.status));
         end
      end
   end

   // Send one reading, then maybe idle the request side
   task automatic send_reading(input logic [19:0] raw_p, input logic [19:0] raw_t,
                               input logic failed);
      int gap;
      req.raw_pressure <= raw_p;
      req.raw_temperature <= raw_t;
      req.read_failed <= failed;
      req.valid <= 1'b1;
      do @(posedge clock); while (!req.ready);
      pending_readings.push_back(compensate(raw_p, raw_t, failed));
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic go_idle();
      req.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Drain, let the pipeline settle, then write all four registers
   task automatic load_calibration(input logic [63:0] w0, input logic [63:0] w1,
                                   input logic [63:0] w2, input logic [63:0] w3);
      logic [63:0] words[4];
      words = '{w0, w1, w2, w3};
      go_idle();
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (90) @(negedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= i[bsc_pkg::CSR_AW-1:0];
         csr_write_data <= words[i];
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
      cal_temp = w0[47:0];
      cal_press_a = w1;
      cal_press_b = w2;
      cal_press_c = w3[15:0];
      @(negedge clock);
   endtask

   function automatic logic [15:0] typical_word(input logic [15:0] base, input int spread);
      logic [15:0] w;
      w = base + 16'($signed($urandom_range(0, 2 * spread)) - spread);
      return w;
   endfunction

   // Calibration near a real part, jittered
   task automatic load_typical_calibration();
      logic [63:0] w0, w1, w2, w3;
      w0 = {$urandom(), $urandom()};
      w0[47:0] = {typical_word(-16'sd1000, 300), typical_word(16'd26435, 2000),
                  typical_word(16'd27504, 2000)};
      w1 = {typical_word(16'd2855, 800), typical_word(16'd3024, 800),
            typical_word(-16'sd10685, 2000), typical_word(16'd36477, 3000)};
      w2 = {typical_word(-16'sd14600, 2000), typical_word(16'd15500, 2000),
            typical_word(-16'sd7, 20), typical_word(16'd140, 100)};
      w3 = {$urandom(), $urandom()};
      w3[15:0] = typical_word(16'd6000, 2000);
      load_calibration(w0, w1, w2, w3);
   endtask

   task automatic send_typical_reading();
      logic [19:0] rp, rt;
      rp = 20'($urandom_range(250000, 600000));
      rt = 20'($urandom_range(440000, 600000));
      send_reading(rp, rt, $urandom_range(0, 15) == 0);
   endtask

   // Reset calibration: divisor is zero
   task automatic test_reset_calibration();
      send_reading(20'd415148, 20'd519888, 1'b0);
      send_reading(20'hFFFFF, 20'd0, 1'b0);
      send_reading(20'd0, 20'hFFFFF, 1'b1);
   endtask

   // Nominal part: both status paths, field extremes
   task automatic test_nominal_calibration();
      load_calibration(64'hFFFF_FC18_6743_6B70, 64'h0B27_0BD0_D643_8E7D,
                       64'hC6F8_3C8C_FFF9_008C, 64'hFFFF_FFFF_FFFF_1770);
      send_reading(20'd415148, 20'd519888, 1'b0);
      send_reading(20'd0, 20'd0, 1'b0);
      send_reading(20'hFFFFF, 20'hFFFFF, 1'b0);
      send_reading(20'd0, 20'hFFFFF, 1'b0);
      send_reading(20'hFFFFF, 20'd0, 1'b0);
      send_reading(20'hFFFFF, 20'hFFFFF, 1'b1);
      send_reading(20'h55555, 20'hAAAAA, 1'b0);
      send_reading(20'hAAAAA, 20'h55555, 1'b0);
   endtask

   // Extreme calibration words, P1 zero forcing a zero divisor
   task automatic test_extreme_calibration();
      load_calibration(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                       64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_reading(20'd0, 20'd0, 1'b0);
      send_reading(20'hFFFFF, 20'hFFFFF, 1'b0);
      load_calibration(64'h0000_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
                       64'h7FFF_7FFF_7FFF_7FFF, 64'h0000_0000_0000_7FFF);
      send_reading(20'd0, 20'd0, 1'b0);
      send_reading(20'hFFFFF, 20'hFFFFF, 1'b0);
      send_reading(20'd123456, 20'd654321, 1'b0);
      load_calibration(64'h0000_8000_8000_0000, 64'h8000_8000_8000_0000,
                       64'h8000_8000_8000_8000, 64'h0000_0000_0000_8000);
      send_reading(20'd0, 20'hFFFFF, 1'b0);
      send_reading(20'hFFFFF, 20'd0, 1'b1);
   endtask

   // Jittered real parts, readings in the working range
   task automatic test_random_typical();
      for (int phase = 0; phase < 6; phase++) begin
         load_typical_calibration();
         for (int n = 0; n < 120; n++) send_typical_reading();
      end
   endtask

   // Fully random calibration and readings
   task automatic test_random_wild();
      for (int phase = 0; phase < 4; phase++) begin
         load_calibration({$urandom(), $urandom()}, {$urandom(), $urandom()},
                          {$urandom(), $urandom()}, {$urandom(), $urandom()});
         for (int n = 0; n < 60; n++)
            send_reading(20'($urandom()), 20'($urandom()), $urandom_range(0, 15) == 0);
      end
   endtask

   // Back-to-back readings with no idling on either side
   task automatic test_full_rate();
      load_typical_calibration();
      quiet = 1;
      for (int n = 0; n < 120; n++) send_typical_reading();
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.raw_pressure = '0;
      req.raw_temperature = '0;
      req.read_failed = 1'b0;
      rsp.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      cal_temp = '0;
      cal_press_a = '0;
      cal_press_b = '0;
      cal_press_c = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_calibration();
      test_nominal_calibration();
      test_extreme_calibration();
      test_random_typical();
      test_random_wild();
      test_full_rate();

      go_idle();
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
